### hdl/lss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the link session supervisor.
// No dependencies; every other file imports this package.

package lss_pkg;

    // Event queue depth and the pointer and fill widths that follow from it.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_POST    = 2'd1;
    localparam logic [1:0] KIND_PROCESS = 2'd2;
    localparam logic [1:0] KIND_TICK    = 2'd3;

    // Event codes; the two remaining codes are dequeued without effect.
    localparam logic [2:0] EV_ATTACHED    = 3'd0;
    localparam logic [2:0] EV_ENUMERATED  = 3'd1;
    localparam logic [2:0] EV_DETACHED    = 3'd2;
    localparam logic [2:0] EV_FRAME       = 3'd3;
    localparam logic [2:0] EV_PROTO_ERROR = 3'd4;
    localparam logic [2:0] EV_CANCEL      = 3'd5;

    // Configuration register word index.
    localparam logic REG_OBSERVE_TIMEOUT = 1'b0;

    // Counter slots.
    localparam int NUM_COUNTERS   = 7;
    localparam int CNT_RECONNECT  = 0;
    localparam int CNT_TIMEOUT    = 1;
    localparam int CNT_GAP        = 2;
    localparam int CNT_SATURATION = 3;
    localparam int CNT_CANCEL     = 4;
    localparam int CNT_ERROR      = 5;
    localparam int CNT_FRAME      = 6;

    typedef enum logic [2:0] {
        ST_BOOTING    = 3'd0,
        ST_DETACHED   = 3'd1,
        ST_ENUMERATED = 3'd2,
        ST_OBSERVING  = 3'd3,
        ST_READY      = 3'd4,
        ST_RECOVERING = 3'd5,
        ST_FAULTED    = 3'd6
    } mode_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  event_kind;
        logic        seq_present;
        logic [31:0] sequence_number;
        logic        conn_req;
        logic        conn_ok;
        logic [31:0] time_now_ms;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  session_state;
        logic [31:0] reconnect_count;
        logic [31:0] timeout_count;
        logic [31:0] gap_count;
        logic [31:0] saturation_count;
        logic [31:0] cancel_count;
        logic [31:0] error_count;
        logic [31:0] frame_count;
        logic [31:0] next_expected_sequence;
    } result_t;

    // One queued event as held in the ring.
    typedef struct packed {
        logic [2:0]  event_kind;
        logic        seq_present;
        logic [31:0] sequence_number;
        logic        conn_req;
        logic        conn_ok;
    } event_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### hdl/lss_queue.sv
`timescale 1ns / 1ps
// Ring queue of posted events with head pointer and fill count.
// Depends on lss_pkg.

module lss_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   pop,
    input  lss_pkg::event_t        push_data,
    output lss_pkg::event_t        head_data,
    output lss_pkg::queue_status_t status
);
    import lss_pkg::*;

    event_t              store_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   head_reg;
    logic [QPTR_W-1:0]   head_next;
    logic [QCNT_W-1:0]   fill_reg;
    logic [QCNT_W-1:0]   fill_next;
    logic [QCNT_W:0]     tail_sum;
    logic [QCNT_W:0]     tail_wrap;
    logic [QPTR_W-1:0]   tail_ptr;
    logic                push_ok;
    logic                pop_ok;

    assign status.full  = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign push_ok      = push && !status.full;
    assign pop_ok       = pop && !status.empty;

    // Head plus fill stays below twice the depth, so one subtract wraps it.
    assign tail_sum  = (QCNT_W+1)'(head_reg) + (QCNT_W+1)'(fill_reg);
    assign tail_wrap = (tail_sum >= (QCNT_W+1)'(QUEUE_DEPTH))
                     ? tail_sum - (QCNT_W+1)'(QUEUE_DEPTH) : tail_sum;
    assign tail_ptr  = tail_wrap[QPTR_W-1:0];

    assign head_data = store_mem[head_reg];

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (push_ok)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (pop_ok)
        begin
            fill_next = fill_reg - QCNT_W'(1);
            head_next = (head_reg == QPTR_W'(QUEUE_DEPTH - 1))
                      ? '0 : head_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            store_mem[tail_ptr] <= push_data;
        end
    end

endmodule

### hdl/lss_session.sv
`timescale 1ns / 1ps
// Session state, observe deadline, sequence tracking and event counters.
// Depends on lss_pkg.

module lss_session (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid,
    input  lss_pkg::item_t         item,
    input  lss_pkg::event_t        head_data,
    input  lss_pkg::queue_status_t qstat,
    input  logic [15:0]            timeout_ms,
    output lss_pkg::result_t       view
);
    import lss_pkg::*;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [31:0] deadline_reg;
    logic [31:0] deadline_next;
    logic [31:0] expect_reg;
    logic [31:0] expect_next;
    logic [31:0] cnt_reg  [NUM_COUNTERS];
    logic [31:0] cnt_next [NUM_COUNTERS];
    logic        accepted_reg;
    logic        accepted_next;
    logic [32:0] dl_sum;
    logic [31:0] new_deadline;

    // Deadline saturates at the top of the time range.
    assign dl_sum       = {1'b0, item.time_now_ms} + 33'(timeout_ms);
    assign new_deadline = dl_sum[32] ? '1 : dl_sum[31:0];

    always_comb
    begin
        mode_next     = mode_reg;
        deadline_next = deadline_reg;
        expect_next   = expect_reg;
        accepted_next = accepted_reg;
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        if (valid)
        begin
            accepted_next = 1'b1;
            unique case (item.kind)
                KIND_START:
                begin
                    if (mode_reg == ST_BOOTING)
                    begin
                        mode_next = ST_DETACHED;
                    end
                end
                KIND_POST:
                begin
                    if (qstat.full)
                    begin
                        cnt_next[CNT_SATURATION] = cnt_reg[CNT_SATURATION] + 32'd1;
                        mode_next                = ST_FAULTED;
                        accepted_next            = 1'b0;
                    end
                end
                KIND_PROCESS:
                begin
                    if (qstat.empty)
                    begin
                        accepted_next = 1'b0;
                    end
                    else if (mode_reg != ST_FAULTED)
                    begin
                        unique case (head_data.event_kind)
                            EV_ATTACHED:
                            begin
                                if (mode_reg != ST_DETACHED)
                                begin
                                    cnt_next[CNT_RECONNECT] = cnt_reg[CNT_RECONNECT] + 32'd1;
                                end
                                mode_next     = ST_ENUMERATED;
                                deadline_next = new_deadline;
                                expect_next   = '0;
                            end
                            EV_ENUMERATED:
                            begin
                                mode_next     = ST_OBSERVING;
                                deadline_next = new_deadline;
                            end
                            EV_DETACHED:
                            begin
                                if (mode_reg != ST_DETACHED)
                                begin
                                    cnt_next[CNT_RECONNECT] = cnt_reg[CNT_RECONNECT] + 32'd1;
                                end
                                mode_next     = ST_DETACHED;
                                deadline_next = '0;
                                expect_next   = '0;
                            end
                            EV_FRAME:
                            begin
                                cnt_next[CNT_FRAME] = cnt_reg[CNT_FRAME] + 32'd1;
                                // Sequence one restarts the count; any other
                                // mismatch is a gap and forces recovery.
                                if (head_data.seq_present && head_data.sequence_number != '0)
                                begin
                                    if (head_data.sequence_number == 32'd1)
                                    begin
                                        expect_next = 32'd2;
                                    end
                                    else if (expect_reg == '0 ||
                                             head_data.sequence_number != expect_reg)
                                    begin
                                        cnt_next[CNT_GAP] = cnt_reg[CNT_GAP] + 32'd1;
                                        expect_next = head_data.sequence_number + 32'd1;
                                        mode_next   = ST_RECOVERING;
                                    end
                                    else
                                    begin
                                        expect_next = expect_reg + 32'd1;
                                    end
                                end
                                if (mode_next != ST_RECOVERING)
                                begin
                                    if (head_data.conn_req && head_data.conn_ok)
                                    begin
                                        mode_next = ST_READY;
                                    end
                                    else if (mode_next != ST_READY)
                                    begin
                                        mode_next = ST_OBSERVING;
                                    end
                                end
                                deadline_next = '0;
                            end
                            EV_PROTO_ERROR:
                            begin
                                cnt_next[CNT_ERROR] = cnt_reg[CNT_ERROR] + 32'd1;
                                mode_next     = ST_RECOVERING;
                                deadline_next = '0;
                            end
                            EV_CANCEL:
                            begin
                                cnt_next[CNT_CANCEL] = cnt_reg[CNT_CANCEL] + 32'd1;
                                mode_next     = ST_RECOVERING;
                                deadline_next = '0;
                                expect_next   = '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                KIND_TICK:
                begin
                    if (deadline_reg != '0 && item.time_now_ms >= deadline_reg &&
                        (mode_reg == ST_ENUMERATED || mode_reg == ST_OBSERVING))
                    begin
                        cnt_next[CNT_TIMEOUT] = cnt_reg[CNT_TIMEOUT] + 32'd1;
                        mode_next     = ST_RECOVERING;
                        deadline_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ST_BOOTING;
            deadline_reg <= '0;
            expect_reg   <= '0;
            accepted_reg <= 1'b0;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            mode_reg     <= mode_next;
            deadline_reg <= deadline_next;
            expect_reg   <= expect_next;
            accepted_reg <= accepted_next;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    assign view.accepted               = accepted_reg;
    assign view.session_state          = mode_reg;
    assign view.reconnect_count        = cnt_reg[CNT_RECONNECT];
    assign view.timeout_count          = cnt_reg[CNT_TIMEOUT];
    assign view.gap_count              = cnt_reg[CNT_GAP];
    assign view.saturation_count       = cnt_reg[CNT_SATURATION];
    assign view.cancel_count           = cnt_reg[CNT_CANCEL];
    assign view.error_count            = cnt_reg[CNT_ERROR];
    assign view.frame_count            = cnt_reg[CNT_FRAME];
    assign view.next_expected_sequence = expect_reg;

endmodule

### hdl/link_session_supervisor.sv
`timescale 1ns / 1ps
// Top level of the link session supervisor: input register, APB register
// port, event queue and session logic. Depends on lss_pkg, lss_queue, lss_session.
//
// Usage:
//   Command channel: an item (kind, event fields, time) is taken at a rising
//   edge where start is high and busy is low. busy is never raised, so one
//   item may be issued every cycle.
//   Result channel: each item yields exactly one result beat, shown on the
//   result port for one cycle while done is high. The item passes first into
//   the input register, then through the queue and session update into the
//   state registers, which drive the result port directly; done follows it
//   through its own valid and done registers. Throughput is one item per
//   cycle, with the queue pointers and session state updated for each item.
//   The receiver cannot stall; a beat it does not take is lost to it, but
//   the state it shows stays on the port until the next item updates it.
//   Configuration: the observe timeout register sits at byte address 0 of
//   the APB port and should only be written while no item is in flight.
//   Reset: rst_n clears the queue, session state, counters and the expected
//   sequence, and restores the observe timeout to 2000 ms. No clearing pass
//   is needed; queue entries are only read after they have been written.

module link_session_supervisor (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             start,
    input  lss_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output lss_pkg::result_t result
);
    import lss_pkg::*;

    logic          timeout_sel;
    logic [15:0]   timeout_ms_reg;
    item_t         item_reg;
    logic          item_valid_reg;
    logic          done_reg;
    logic          cfg_write;
    event_t        push_data;
    event_t        head_data;
    queue_status_t qstat;
    logic          push;
    logic          pop;

    // The block takes a command every cycle.
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // Register write completes on the access cycle; paddr[2] selects the word.
    assign cfg_write   = psel && penable && pwrite && pready;
    assign timeout_sel = (paddr[2] == REG_OBSERVE_TIMEOUT);
    assign prdata      = timeout_sel ? {16'd0, timeout_ms_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ms_reg <= TIMEOUT_RESET;
        end
        else if (cfg_write && timeout_sel)
        begin
            timeout_ms_reg <= pwdata[15:0];
        end
    end

    // Input register: the command is captured here and processed in the next
    // cycle, when its result is loaded into the session state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
            done_reg       <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
    end

    assign push = item_valid_reg && (item_reg.kind == KIND_POST);
    assign pop  = item_valid_reg && (item_reg.kind == KIND_PROCESS);

    assign push_data.event_kind      = item_reg.event_kind;
    assign push_data.seq_present     = item_reg.seq_present;
    assign push_data.sequence_number = item_reg.sequence_number;
    assign push_data.conn_req        = item_reg.conn_req;
    assign push_data.conn_ok         = item_reg.conn_ok;

    lss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .push_data (push_data),
        .head_data (head_data),
        .status    (qstat)
    );

    // The session registers double as the result register.
    lss_session u_session (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (item_valid_reg),
        .item       (item_reg),
        .head_data  (head_data),
        .qstat      (qstat),
        .timeout_ms (timeout_ms_reg),
        .view       (result)
    );

    assign done = done_reg;

endmodule

### hdl/lss_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the link session supervisor and the bind that
// attaches them to the top level. Depends on lss_pkg and link_session_supervisor.

module lss_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input lss_pkg::item_t   item,
    input logic             done,
    input lss_pkg::result_t result
);
    import lss_pkg::*;

    logic settled;

    assign settled = rst_n;

    // Every taken command yields exactly one beat, through the valid and done registers.
    a_beat_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(settled) && $past(settled, 2)) |-> (done == $past(start && !busy, 2)))
        else $error("result beat does not follow its command by two cycles");

    // Start and tick commands are always reported as accepted.
    a_start_tick_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(settled) && $past(settled, 2) && $past(start && !busy, 2) &&
         ($past(item.kind, 2) == KIND_START || $past(item.kind, 2) == KIND_TICK))
        |-> result.accepted)
        else $error("start or tick beat not marked accepted");

    // A refused post bumps the saturation count and leaves the block faulted.
    a_refused_post: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.accepted && $past(settled) && $past(settled, 2) &&
         $past(start && !busy, 2) && $past(item.kind, 2) == KIND_POST)
        |-> (result.saturation_count == $past(result.saturation_count) + 32'd1 &&
             result.session_state == ST_FAULTED))
        else $error("refused post did not count saturation and fault");

    // Only reset leaves the faulted state.
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(settled) && $past(result.session_state) == ST_FAULTED)
        |-> (result.session_state == ST_FAULTED))
        else $error("session left the faulted state without reset");

endmodule

bind link_session_supervisor lss_checker u_lss_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
